// ===== hdl/bounded_array_list_engine_macros.svh =====
// Assertion macros shared by the checker of the bounded array list engine.
// Depends on nothing; include by bare file name.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH

// Checked only outside reset.
`define BALE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define BALE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/bale_pkg.sv =====
// Shared types and constants of the bounded array list engine.
// Used by the controller, the datapath, the top level and the checker.
package bale_pkg;

   localparam int DEPTH_DEF  = 32;
   localparam int FUNC_W     = 3;
   localparam int POS_W      = 16;
   localparam int WORD_W     = 32;
   localparam int FOUND_W    = 6;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 6;
   localparam int CAP_W      = 6;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   localparam logic [CAP_W-1:0]   CAP_RESET  = 6'd32;
   localparam logic [FOUND_W-1:0] FOUND_NONE = 6'h3F;

   typedef enum logic [FUNC_W-1:0] {
      FN_GET    = 3'd0,
      FN_SET    = 3'd1,
      FN_INSERT = 3'd2,
      FN_REMOVE = 3'd3,
      FN_SEARCH = 3'd4,
      FN_MAX    = 3'd5,
      FN_MIN    = 3'd6,
      FN_CLEAR  = 3'd7
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_CLAMPED  = 3'd2,
      ST_RANGE    = 3'd3,
      ST_FULL     = 3'd4,
      ST_NOTFOUND = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SWEEP,
      S_DRAIN,
      S_FINAL,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // latch the request
      logic decode;   // register decode results and new count
      logic rd;       // issue one memory read and advance the pointer
      logic fin;      // final single write
      logic emit;     // load the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic dec_sweep;
      logic dec_fin;
      logic fin;
      logic last;
      logic slot_free;
   } stat_type;

endpackage

// ===== hdl/bounded_array_list_engine.sv =====
// Top level of the bounded array list engine: controller plus datapath.
// Depends on bale_pkg, bale_ctrl and bale_dpath.
//
// Usage:
//   req channel: one operation per transfer. req_tuser carries the function
//   code, req_tdata the signed position (bits 15:0) and signed word (47:16).
//   rsp channel: exactly one result per operation, in order. rsp_tdata holds
//   word_out (31:0), found_at (37:32), count (43:38), zeros above; rsp_tuser
//   holds the status code.
//   csr channel: writes capacity_limit; csr_ready is always high. Write only
//   while no operation is in flight.
// Sequencing: a successful get reads one entry, set writes one, and an append
//   writes its word without a walk. Insert, remove, search, max and min walk
//   the entry memory one entry per cycle through its single read port, at
//   most DEPTH entries, and insert then writes its word. The next request is
//   taken only after the result moves into the output register.
// Reset: count goes to zero, capacity to 32, no result pending. Entry words
//   are not cleared; a word is never read before it is written.
// Stall: a held result stays stable; a finished operation waits for the
//   output register to free up before the block takes another request.
module bounded_array_list_engine #(
   parameter int DEPTH = bale_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bale_pkg::REQ_DATA_W-1:0] req_tdata,  // position, word_in
   input  logic [bale_pkg::FUNC_W-1:0]     req_tuser,  // func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bale_pkg::RSP_DATA_W-1:0] rsp_tdata,  // word_out, found_at, count
   output logic [bale_pkg::STATUS_W-1:0]   rsp_tuser,  // status
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bale_pkg::CAP_W-1:0]      csr_data    // capacity_limit
);
   import bale_pkg::*;

   cmd_type  cmd;
   stat_type st;

   assign csr_ready = 1'b1;

   bale_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bale_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

// ===== hdl/bale_ctrl.sv =====
// Controller of the bounded array list engine: sequences decode, memory
// sweep, final write and response. Depends on bale_pkg.
module bale_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  bale_pkg::stat_type st,
   output bale_pkg::cmd_type  cmd
);
   import bale_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (st.dec_sweep) begin
               state_in = S_SWEEP;
            end else if (st.dec_fin) begin
               state_in = S_FINAL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SWEEP: begin
            cmd.rd = 1'b1;
            if (st.last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last read data is consumed in this cycle
            if (st.fin) begin
               state_in = S_FINAL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FINAL: begin
            cmd.fin  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (st.slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/bale_dpath.sv =====
// Datapath of the bounded array list engine: entry memory, count, capacity
// register, decode, sweep pointer and response register. Depends on bale_pkg.
module bale_dpath #(
   parameter int DEPTH = bale_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [bale_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [bale_pkg::FUNC_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bale_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [bale_pkg::STATUS_W-1:0]   rsp_tuser,
   input  logic                            csr_valid,
   input  logic [bale_pkg::CAP_W-1:0]      csr_data,
   input  bale_pkg::cmd_type                cmd,
   output bale_pkg::stat_type               st
);
   import bale_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int PW = (CW + 1 > POS_W + 1) ? CW + 1 : POS_W + 1;
   localparam int XW = (CW > CAP_W) ? CW : CAP_W;

   logic [WORD_W-1:0] mem [DEPTH];

   func_type                 op_ff;
   logic signed [POS_W-1:0]  pos_ff;
   logic [WORD_W-1:0]        word_ff;
   logic [CW-1:0]            cnt_ff;
   logic [CAP_W-1:0]         cap_ff;
   logic [AW-1:0]            rd_addr_ff, end_ff, first_ff, widx_ff, rv_addr_ff;
   logic                     down_ff, fin_ff, rv_ff, hit_ff;
   logic [WORD_W-1:0]        rdata_ff, wout_ff;
   logic [FOUND_W-1:0]       found_ff;
   status_type               status_ff;
   logic                     rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]    rsp_tdata_ff;
   logic [STATUS_W-1:0]      rsp_tuser_ff;

   // decode
   logic signed [PW-1:0] pos_x, n_x;
   logic                 pos_neg, pos_ge, pos_gt, empty, full;
   logic [CW-1:0]        cnt_m1;
   logic [AW-1:0]        pos_a, last_a, cnt_a, ins_idx;
   logic [XW-1:0]        cap_x, cap_eff;
   logic                 ins_clamp;
   status_type           d_status;
   logic                 d_sweep, d_fin, d_down;
   logic [AW-1:0]        d_start, d_end, d_widx;
   logic [CW-1:0]        d_cnt;

   // sweep write
   logic                 sw_we;
   logic [AW-1:0]        sw_wa;

   always_comb begin
      pos_x   = PW'(pos_ff);
      n_x     = PW'(cnt_ff);
      pos_neg = pos_ff[POS_W-1];
      pos_ge  = pos_x >= n_x;
      pos_gt  = pos_x > n_x;
      empty   = cnt_ff == '0;
      cnt_m1  = cnt_ff - CW'(1);
      pos_a   = pos_ff[AW-1:0];
      last_a  = cnt_m1[AW-1:0];
      cnt_a   = cnt_ff[AW-1:0];
      cap_x   = XW'(cap_ff);
      if (cap_x == '0) begin
         cap_eff = XW'(1);
      end else if (cap_x > XW'(DEPTH)) begin
         cap_eff = XW'(DEPTH);
      end else begin
         cap_eff = cap_x;
      end
      full = XW'(cnt_ff) >= cap_eff;

      ins_clamp = pos_neg || pos_gt;
      if (pos_neg) begin
         ins_idx = '0;
      end else if (pos_gt) begin
         ins_idx = cnt_a;
      end else begin
         ins_idx = pos_a;
      end

      d_status = ST_OK;
      d_sweep  = 1'b0;
      d_fin    = 1'b0;
      d_down   = 1'b0;
      d_start  = '0;
      d_end    = '0;
      d_widx   = '0;
      d_cnt    = cnt_ff;
      unique case (op_ff) inside
         FN_GET: begin
            if (empty) begin
               d_status = ST_EMPTY;
            end else begin
               d_sweep = 1'b1;
               if (pos_neg) begin
                  d_status = ST_CLAMPED;
                  d_start  = '0;
               end else if (pos_ge) begin
                  d_status = ST_CLAMPED;
                  d_start  = last_a;
               end else begin
                  d_start = pos_a;
               end
               d_end = d_start;
            end
         end
         FN_SET: begin
            if (empty) begin
               d_status = ST_EMPTY;
            end else if (pos_neg || pos_ge) begin
               d_status = ST_RANGE;
            end else begin
               d_fin  = 1'b1;
               d_widx = pos_a;
            end
         end
         FN_INSERT: begin
            if (full) begin
               d_status = ST_FULL;
            end else begin
               if (ins_clamp) begin
                  d_status = ST_CLAMPED;
               end else begin
                  d_status = ST_OK;
               end
               d_cnt    = cnt_ff + CW'(1);
               d_fin    = 1'b1;
               d_widx   = ins_idx;
               // open a gap by moving the tail up one place
               d_sweep  = ins_idx != cnt_a;
               d_down   = 1'b1;
               d_start  = last_a;
               d_end    = ins_idx;
            end
         end
         FN_REMOVE: begin
            if (empty) begin
               d_status = ST_EMPTY;
            end else if (pos_neg || pos_ge) begin
               d_status = ST_RANGE;
            end else begin
               d_sweep = 1'b1;
               d_start = pos_a;
               d_end   = last_a;
               d_cnt   = cnt_m1;
            end
         end
         FN_SEARCH: begin
            if (empty) begin
               d_status = ST_EMPTY;
            end else begin
               d_status = ST_NOTFOUND;
               d_sweep  = 1'b1;
               d_end    = last_a;
            end
         end
         FN_MAX, FN_MIN: begin
            if (empty) begin
               d_status = ST_EMPTY;
            end else begin
               d_sweep = 1'b1;
               d_end   = last_a;
            end
         end
         FN_CLEAR: begin
            d_cnt = '0;
         end
         default: begin
            d_status = ST_OK;
         end
      endcase
   end

   always_comb begin
      sw_we = rv_ff && ((op_ff == FN_INSERT) ||
                        ((op_ff == FN_REMOVE) && (rv_addr_ff != first_ff)));
      sw_wa = (op_ff == FN_INSERT) ? rv_addr_ff + AW'(1) : rv_addr_ff - AW'(1);
   end

   always_comb begin
      st.dec_sweep = d_sweep;
      st.dec_fin   = d_fin;
      st.fin       = fin_ff;
      st.last      = rd_addr_ff == end_ff;
      st.slot_free = !rsp_tvalid_ff || rsp_tready;
   end

   // entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         mem[widx_ff] <= word_ff;
      end else if (sw_we) begin
         mem[sw_wa] <= rdata_ff;
      end
      if (cmd.rd) begin
         rdata_ff <= mem[rd_addr_ff];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         cap_ff        <= CAP_RESET;
         rv_ff         <= 1'b0;
         fin_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
         if (cmd.decode) begin
            cnt_ff <= d_cnt;
            fin_ff <= d_fin;
         end
         rv_ff <= cmd.rd;
         if (cmd.emit) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= func_type'(req_tuser);
         pos_ff  <= req_tdata[POS_W-1:0];
         word_ff <= req_tdata[POS_W +: WORD_W];
      end
      if (cmd.decode) begin
         status_ff  <= d_status;
         wout_ff    <= '0;
         found_ff   <= FOUND_NONE;
         hit_ff     <= 1'b0;
         rd_addr_ff <= d_start;
         first_ff   <= d_start;
         end_ff     <= d_end;
         down_ff    <= d_down;
         widx_ff    <= d_widx;
      end
      if (cmd.rd) begin
         rv_addr_ff <= rd_addr_ff;
         rd_addr_ff <= down_ff ? rd_addr_ff - AW'(1) : rd_addr_ff + AW'(1);
      end
      if (rv_ff) begin
         case (op_ff)
            FN_GET: begin
               wout_ff <= rdata_ff;
            end
            FN_REMOVE: begin
               if (rv_addr_ff == first_ff) begin
                  wout_ff <= rdata_ff;
               end
            end
            FN_SEARCH: begin
               if (!hit_ff && (rdata_ff == word_ff)) begin
                  hit_ff    <= 1'b1;
                  found_ff  <= FOUND_W'(rv_addr_ff);
                  status_ff <= ST_OK;
               end
            end
            FN_MAX: begin
               if ((rv_addr_ff == first_ff) ||
                   ($signed(rdata_ff) > $signed(wout_ff))) begin
                  wout_ff <= rdata_ff;
               end
            end
            FN_MIN: begin
               if ((rv_addr_ff == first_ff) ||
                   ($signed(rdata_ff) < $signed(wout_ff))) begin
                  wout_ff <= rdata_ff;
               end
            end
            default: begin
               wout_ff <= wout_ff;
            end
         endcase
      end
      if (cmd.emit) begin
         rsp_tdata_ff <= {{(RSP_DATA_W - WORD_W - FOUND_W - COUNT_W){1'b0}},
                          COUNT_W'(cnt_ff), found_ff, wout_ff};
         rsp_tuser_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== hdl/bale_chk.sv =====
// Port-level checker of the bounded array list engine, bound to the top.
// Depends on bale_pkg and bounded_array_list_engine_macros.svh.
`include "bounded_array_list_engine_macros.svh"

module bale_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bale_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [bale_pkg::STATUS_W-1:0]   rsp_tuser
);
   import bale_pkg::*;

   logic no_match_field;
   logic no_word_status;
   logic req_xfer;
   logic rsp_stall;
   logic fail_rsp;
   logic bare_rsp;
   logic word_zero;

   assign no_match_field = rsp_tdata[WORD_W +: FOUND_W] == FOUND_NONE;
   assign no_word_status = (rsp_tuser == ST_EMPTY) || (rsp_tuser == ST_RANGE) ||
                           (rsp_tuser == ST_FULL) || (rsp_tuser == ST_NOTFOUND);
   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign fail_rsp  = rsp_tvalid && (rsp_tuser != ST_OK);
   assign bare_rsp  = rsp_tvalid && no_word_status;
   assign word_zero = rsp_tdata[WORD_W-1:0] == '0;

   `BALE_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "result pending after reset")
   `BALE_ASSERT(a_one_at_a_time, req_xfer |=> !req_tready, "request taken while busy")
   `BALE_ASSERT(a_found_only_ok, fail_rsp |-> no_match_field, "match index on failed op")
   `BALE_ASSERT(a_no_word, bare_rsp |-> word_zero, "word on no-value status")
   `BALE_ASSERT(a_rsp_hold, rsp_stall |=> (rsp_tvalid && $stable(rsp_tdata)), "result dropped")

endmodule

bind bounded_array_list_engine bale_chk u_bale_chk (.*);
